// ===== rtl/png_unf_pkg.sv =====
// Shared types and constants for the PNG scanline unfilter unit.
// No dependencies; png_unf_predict and the top level import this package.

package png_unf_pkg;

   // Widest pixel the filters reach back over, in bytes.
   localparam int MAX_PIXEL_BYTES = 8;
   localparam int PIX_IDX_W       = $clog2(MAX_PIXEL_BYTES);
   localparam int BPP_W           = 4;

   typedef enum logic [2:0] {
      FILT_NONE    = 3'd0,
      FILT_SUB     = 3'd1,
      FILT_UP      = 3'd2,
      FILT_AVERAGE = 3'd3,
      FILT_PAETH   = 3'd4
   } filter_type;

   typedef enum logic [1:0] {
      ERR_OK         = 2'd0,
      ERR_BAD_FILTER = 2'd1,
      ERR_OVERLONG   = 2'd2
   } error_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       line_start;
      logic       pass_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] error_code;
   } rsp_type;

endpackage

// ===== rtl/png_unf_ram.sv =====
// Generic single-clock RAM: one write port and one read port with registered read data.
// No dependencies.

module png_unf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/png_unf_predict.sv =====
// Filter predictor and reconstruction adder for one data byte.
// Depends on png_unf_pkg for the filter codes.

module png_unf_predict
   import png_unf_pkg::*;
(
   input  filter_type filter,
   input  logic [7:0] filt_byte,
   input  logic [7:0] left_byte,
   input  logic [7:0] above_byte,
   input  logic [7:0] upper_left_byte,
   output logic [7:0] raw_byte
);

   logic signed [9:0] diff_bc;
   logic signed [9:0] diff_ac;
   logic signed [9:0] diff_sum;
   logic [9:0]        dist_a;
   logic [9:0]        dist_b;
   logic [9:0]        dist_c;
   logic [7:0]        paeth;
   logic [8:0]        avg_sum;
   logic [7:0]        pred;

   // With p = a + b - c the three distances reduce to |b-c|, |a-c| and |(b-c)+(a-c)|.
   always_comb begin
      diff_bc  = $signed({2'b00, above_byte}) - $signed({2'b00, upper_left_byte});
      diff_ac  = $signed({2'b00, left_byte}) - $signed({2'b00, upper_left_byte});
      diff_sum = diff_bc + diff_ac;
      dist_a   = (diff_bc < 0) ? 10'(-diff_bc) : 10'(diff_bc);
      dist_b   = (diff_ac < 0) ? 10'(-diff_ac) : 10'(diff_ac);
      dist_c   = (diff_sum < 0) ? 10'(-diff_sum) : 10'(diff_sum);
      if ((dist_a <= dist_b) && (dist_a <= dist_c)) begin
         paeth = left_byte;
      end else if (dist_b <= dist_c) begin
         paeth = above_byte;
      end else begin
         paeth = upper_left_byte;
      end
   end

   always_comb begin
      avg_sum = {1'b0, left_byte} + {1'b0, above_byte};
      case (filter)
         FILT_SUB:     pred = left_byte;
         FILT_UP:      pred = above_byte;
         FILT_AVERAGE: pred = avg_sum[8:1];
         FILT_PAETH:   pred = paeth;
         default:      pred = 8'd0;
      endcase
      raw_byte = filt_byte + pred;
   end

endmodule

// ===== rtl/png_scanline_unfilter_unit.sv =====
// PNG scanline unfilter unit, top level.
// Depends on png_unf_pkg, png_unf_ram and png_unf_predict.

// Reconstructs PNG filtered scanlines one byte per cycle while rsp_ready is held high. A
// beat with line_start carries the filter type of a new line; pass_start with it makes the
// line above read as zero. The following beats are data bytes, each answered by one
// reconstructed byte. Items pass through two registers: at acceptance the line store is
// read at the byte position, and when the output register is free the byte is
// reconstructed, written back to the store and loaded into the output register. With
// rsp_ready held high a new beat is taken every cycle; the line store does one read and one
// write per cycle. A held-off result stalls the input only once the reconstruction stage
// also holds a beat. An invalid filter type answers with error code 1, and data beyond
// MAX_LINE_BYTES in one line answer with error code 2. Write the pixel size register only
// while the unit is idle.

module png_scanline_unfilter_unit
   import png_unf_pkg::*;
#(
   parameter int MAX_LINE_BYTES = 32768
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [BPP_W-1:0] csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_LINE_BYTES);
   localparam int POS_W  = $clog2(MAX_LINE_BYTES + 1);

   // Configuration and per-line control.
   logic [BPP_W-1:0] bpp_ff;
   logic [BPP_W-1:0] reach;
   logic [POS_W-1:0] byte_position_ff, byte_position_in;
   filter_type       line_filter_ff, line_filter_in;
   logic             first_line_ff, first_line_in;

   // Reconstruction stage.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_emit_ff;
   logic             s1_data_ff;
   error_type        s1_err_ff;
   logic [7:0]       s1_byte_ff;
   logic [POS_W-1:0] s1_pos_ff;
   filter_type       s1_filter_ff;
   logic             s1_first_ff;
   logic             s1_adv;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   logic [7:0]       left_hist_ff [MAX_PIXEL_BYTES];
   logic [7:0]       ul_hist_ff   [MAX_PIXEL_BYTES];

   logic                 req_fire;
   logic                 in_range;
   logic                 bad_filter;
   logic                 ram_rd_en;
   logic                 ram_wr_en;
   logic [7:0]           ram_rd_data;
   logic [PIX_IDX_W-1:0] slot;
   logic [PIX_IDX_W-1:0] back;
   logic                 past_edge;
   logic [7:0]           a_byte, b_byte, c_byte;
   logic [7:0]           raw_byte;
   logic                 u_line_store_wr_addr_ne;

   assign req_fire   = req_valid && req_ready;
   assign in_range   = byte_position_ff < POS_W'(MAX_LINE_BYTES);
   assign bad_filter = req_data.byte_value > 8'(FILT_PAETH);

   // A value of zero acts as one; anything above the widest pixel is clamped.
   always_comb begin
      if (bpp_ff == '0) begin
         reach = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(MAX_PIXEL_BYTES)) begin
         reach = BPP_W'(MAX_PIXEL_BYTES);
      end else begin
         reach = bpp_ff;
      end
   end

   // A quiet line-start beat leaves the stage without waiting for the output register.
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      byte_position_in = byte_position_ff;
      line_filter_in   = line_filter_ff;
      first_line_in    = first_line_ff;
      if (req_fire) begin
         if (req_data.line_start) begin
            byte_position_in = '0;
            first_line_in    = req_data.pass_start;
            line_filter_in   = bad_filter ? FILT_NONE : filter_type'(req_data.byte_value[2:0]);
         end else if (in_range) begin
            byte_position_in = byte_position_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff           <= BPP_W'(1);
         byte_position_ff <= '0;
         line_filter_ff   <= FILT_NONE;
         first_line_ff    <= 1'b1;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            bpp_ff <= csr_wr_data;
         end
         byte_position_ff <= byte_position_in;
         line_filter_ff   <= line_filter_in;
         first_line_ff    <= first_line_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff   <= req_data.byte_value;
         s1_pos_ff    <= byte_position_ff;
         s1_filter_ff <= line_filter_ff;
         s1_first_ff  <= first_line_ff;
         if (req_data.line_start) begin
            s1_emit_ff <= bad_filter;
            s1_data_ff <= 1'b0;
            s1_err_ff  <= ERR_BAD_FILTER;
         end else if (in_range) begin
            s1_emit_ff <= 1'b1;
            s1_data_ff <= 1'b1;
            s1_err_ff  <= ERR_OK;
         end else begin
            s1_emit_ff <= 1'b1;
            s1_data_ff <= 1'b0;
            s1_err_ff  <= ERR_OVERLONG;
         end
      end
      if (s1_adv && s1_emit_ff) begin
         rsp_data_ff.out_byte   <= s1_data_ff ? raw_byte : 8'd0;
         rsp_data_ff.error_code <= s1_err_ff;
      end
   end

   // The store is read when a data beat is taken and written when it leaves the stage.
   // Inside a line the two addresses differ, and the line-start beat separates the last
   // write of one line from the first read of the next.
   assign ram_rd_en = req_fire && !req_data.line_start && in_range;
   assign ram_wr_en = s1_adv && s1_data_ff;

   png_unf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LINE_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_pos_ff[ADDR_W-1:0]),
      .wr_data (raw_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (byte_position_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign slot      = s1_pos_ff[PIX_IDX_W-1:0];
   assign back      = slot - reach[PIX_IDX_W-1:0];
   assign past_edge = s1_pos_ff >= POS_W'(reach);
   assign b_byte    = s1_first_ff ? 8'd0 : ram_rd_data;
   assign a_byte    = past_edge ? left_hist_ff[back] : 8'd0;
   assign c_byte    = past_edge ? ul_hist_ff[back] : 8'd0;

   png_unf_predict u_predict (
      .filter          (s1_filter_ff),
      .filt_byte       (s1_byte_ff),
      .left_byte       (a_byte),
      .above_byte      (b_byte),
      .upper_left_byte (c_byte),
      .raw_byte        (raw_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_hist_ff[i] <= 8'd0;
            ul_hist_ff[i]   <= 8'd0;
         end
      end else if (ram_wr_en) begin
         left_hist_ff[slot] <= raw_byte;
         ul_hist_ff[slot]   <= b_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign u_line_store_wr_addr_ne =
      s1_pos_ff[ADDR_W-1:0] != byte_position_ff[ADDR_W-1:0];

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (u_line_store_wr_addr_ne))
      else $error("line store read and written at the same entry");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff <= POS_W'(MAX_LINE_BYTES))
      else $error("byte position ran past the line store");

   a_stall_holds_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !ram_rd_en)
      else $error("line store read while the reconstruction stage is stalled");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.error_code != ERR_OK)) |-> (rsp_data_ff.out_byte == 8'd0))
      else $error("error result carries a nonzero byte");

endmodule
